### rtl/core/triangle_tangent_frame_core_assert.svh
// Assertion macros shared by the tangent frame core.
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef TRIANGLE_TANGENT_FRAME_CORE_ASSERT_SVH
`define TRIANGLE_TANGENT_FRAME_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TTF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TTF_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TTF_ASSERT(name, prop, msg)
`define TTF_ASSERT_NEVER(name, cond, msg)
`endif
`endif

### rtl/core/ttf_pkg.sv
// Package for the tangent frame core: widths, slot and corner codes,
// and the command and status structs between controller and datapath.
package ttf_pkg;

  localparam int INDEX_BITS = 16;
  localparam int IDX_KEEP   = (INDEX_BITS < 16) ? INDEX_BITS : 16;
  localparam int IDX_W      = 16;
  localparam int POS_W      = 32;
  localparam int NRM_W      = 16;
  localparam int UNIT_W     = 16;
  localparam int VEC_W      = 35;

  localparam logic [1:0] SLOT_V0 = 2'd0;
  localparam logic [1:0] SLOT_V1 = 2'd1;
  localparam logic [1:0] SLOT_V2 = 2'd2;

  localparam logic [1:0] CORNER_0 = 2'd0;
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;

  localparam logic [2:0] CROSS_LAST = 3'd5;

  typedef struct packed {
    logic       load;
    logic [1:0] slot;
    logic [1:0] corner;
    logic       odd;
    logic       tan_go;
    logic       tan_save;
    logic       cross_en;
    logic [2:0] cross_step;
    logic       bin_go;
    logic       put;
  } ttf_cmd_t;

  typedef struct packed {
    logic norm_done;
  } ttf_sts_t;

endpackage

### rtl/core/triangle_tangent_frame_core.sv
// Top level of the tangent frame core: controller plus datapath.
// Depends on ttf_pkg, ttf_ctrl, ttf_datapath and ttf_norm.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o  | vertex index, position, normal, first flag
//   out     | output    | out_valid_o/out_ready_i| corner index, tangent, binormal, last flag
//
// The first two vertices of a triangle are only loaded into the held corners.
// The third runs three corners; each corner uses the shared normalizer twice
// (a shift search, 21 root steps and a divide per component; a zero vector
// ends after the shift search) plus the cross product and the output of the
// corner.
// Reset clears all control state; no clearing pass is needed.
// A stalled output holds the result register and the sequence waits for it.
module triangle_tangent_frame_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ttf_pkg::IDX_W-1:0]         vertex_index_i,
  input  logic signed [ttf_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [ttf_pkg::POS_W-1:0]  pos_y_i,
  input  logic signed [ttf_pkg::POS_W-1:0]  pos_z_i,
  input  logic signed [ttf_pkg::NRM_W-1:0]  norm_x_i,
  input  logic signed [ttf_pkg::NRM_W-1:0]  norm_y_i,
  input  logic signed [ttf_pkg::NRM_W-1:0]  norm_z_i,
  input  logic                              first_of_mesh_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ttf_pkg::IDX_W-1:0]         out_index_o,
  output logic signed [ttf_pkg::UNIT_W-1:0] tan_x_o,
  output logic signed [ttf_pkg::UNIT_W-1:0] tan_y_o,
  output logic signed [ttf_pkg::UNIT_W-1:0] tan_z_o,
  output logic signed [ttf_pkg::UNIT_W-1:0] bin_x_o,
  output logic signed [ttf_pkg::UNIT_W-1:0] bin_y_o,
  output logic signed [ttf_pkg::UNIT_W-1:0] bin_z_o,
  output logic                              last_of_triangle_o
);
  import ttf_pkg::*;

  ttf_cmd_t cmd;
  ttf_sts_t sts;

  ttf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .first_i     (first_of_mesh_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ttf_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .vertex_index_i     (vertex_index_i),
    .pos_x_i            (pos_x_i),
    .pos_y_i            (pos_y_i),
    .pos_z_i            (pos_z_i),
    .norm_x_i           (norm_x_i),
    .norm_y_i           (norm_y_i),
    .norm_z_i           (norm_z_i),
    .out_index_o        (out_index_o),
    .tan_x_o            (tan_x_o),
    .tan_y_o            (tan_y_o),
    .tan_z_o            (tan_z_o),
    .bin_x_o            (bin_x_o),
    .bin_y_o            (bin_y_o),
    .bin_z_o            (bin_z_o),
    .last_of_triangle_o (last_of_triangle_o)
  );

endmodule

### rtl/core/ttf_norm.sv
// Iterative vector normalizer: block-shift, sum of squares, digit-by-digit
// square root and restoring division per component. Uses ttf_pkg.
module ttf_norm (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [ttf_pkg::VEC_W-1:0] vec_i [3],
  output logic                             done_o,
  output logic signed [ttf_pkg::UNIT_W-1:0] res_o [3]
);
  import ttf_pkg::*;

  typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_ROOT, N_DLOAD, N_DIV} phase_e;

  localparam logic [41:0] ROOT_TOP   = 42'h1 << 40;
  localparam logic [4:0]  ROOT_LAST  = 5'd20;
  localparam logic [4:0]  DIV_LAST   = 5'd14;
  localparam logic [1:0]  COMP_LAST  = 2'd2;

  phase_e                     phase_q;
  logic [VEC_W-1:0]           m_q [3];
  logic                       neg_q [3];
  logic [41:0]                s_q, x_q, r_q;
  logic [21:0]                rem_q;
  logic [14:0]                low_q, quo_q;
  logic [4:0]                 cnt_q;
  logic [1:0]                 k_q;
  logic signed [UNIT_W-1:0]   res_q [3];
  logic                       done_q;

  logic [VEC_W-1:0] mx;
  logic [39:0]      sq;
  logic [41:0]      bit_w;
  logic [42:0]      trial;
  logic [20:0]      len;
  logic [35:0]      num;
  logic [22:0]      rem2, dvs;
  logic             ge;
  logic [14:0]      quo_n;

  always_comb begin
    mx = m_q[0];
    if (m_q[1] > mx) mx = m_q[1];
    if (m_q[2] > mx) mx = m_q[2];
    sq    = m_q[k_q][19:0] * m_q[k_q][19:0];
    bit_w = ROOT_TOP >> {cnt_q, 1'b0};
    trial = {1'b0, r_q} + {1'b0, bit_w};
    len   = r_q[20:0];
    num   = {1'b0, m_q[k_q][19:0], 15'b0} + 36'(len);
    rem2  = {rem_q, low_q[14]};
    dvs   = {1'b0, len, 1'b0};
    ge    = (rem2 >= dvs);
    quo_n = {quo_q[13:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= N_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      k_q     <= '0;
      s_q     <= '0;
      x_q     <= '0;
      r_q     <= '0;
      rem_q   <= '0;
      low_q   <= '0;
      quo_q   <= '0;
      for (int i = 0; i < 3; i++) begin
        m_q[i]   <= '0;
        neg_q[i] <= 1'b0;
        res_q[i] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      case (phase_q)
        N_IDLE: begin
          if (start_i) begin
            for (int i = 0; i < 3; i++) begin
              neg_q[i] <= vec_i[i][VEC_W-1];
              m_q[i]   <= vec_i[i][VEC_W-1] ? VEC_W'(-vec_i[i]) : VEC_W'(vec_i[i]);
            end
            phase_q <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (mx == '0) begin
            for (int i = 0; i < 3; i++) res_q[i] <= '0;
            done_q  <= 1'b1;
            phase_q <= N_IDLE;
          end else if (|mx[VEC_W-1:20]) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
          end else if (!mx[19]) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
          end else begin
            s_q     <= '0;
            k_q     <= '0;
            phase_q <= N_SQ;
          end
        end
        N_SQ: begin
          s_q <= s_q + 42'(sq);
          if (k_q == COMP_LAST) begin
            x_q     <= s_q + 42'(sq);
            r_q     <= '0;
            cnt_q   <= '0;
            phase_q <= N_ROOT;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        N_ROOT: begin
          if ({1'b0, x_q} >= trial) begin
            x_q <= x_q - trial[41:0];
            r_q <= (r_q >> 1) + bit_w;
          end else begin
            r_q <= r_q >> 1;
          end
          if (cnt_q == ROOT_LAST) begin
            k_q     <= '0;
            phase_q <= N_DLOAD;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        N_DLOAD: begin
          rem_q   <= 22'(num[35:15]);
          low_q   <= num[14:0];
          quo_q   <= '0;
          cnt_q   <= '0;
          phase_q <= N_DIV;
        end
        N_DIV: begin
          rem_q <= ge ? 22'(rem2 - dvs) : rem2[21:0];
          low_q <= low_q << 1;
          quo_q <= quo_n;
          if (cnt_q == DIV_LAST) begin
            res_q[k_q] <= neg_q[k_q] ? -UNIT_W'({1'b0, quo_n}) : UNIT_W'({1'b0, quo_n});
            if (k_q == COMP_LAST) begin
              done_q  <= 1'b1;
              phase_q <= N_IDLE;
            end else begin
              k_q     <= k_q + 2'd1;
              phase_q <= N_DLOAD;
            end
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        default: phase_q <= N_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### rtl/core/ttf_datapath.sv
// Datapath: held corners, edge difference, cross product on one multiplier,
// the shared normalizer and the output registers. Uses ttf_pkg and ttf_norm.
module ttf_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ttf_pkg::ttf_cmd_t                 cmd_i,
  output ttf_pkg::ttf_sts_t                 sts_o,
  input  logic [ttf_pkg::IDX_W-1:0]         vertex_index_i,
  input  logic signed [ttf_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [ttf_pkg::POS_W-1:0]  pos_y_i,
  input  logic signed [ttf_pkg::POS_W-1:0]  pos_z_i,
  input  logic signed [ttf_pkg::NRM_W-1:0]  norm_x_i,
  input  logic signed [ttf_pkg::NRM_W-1:0]  norm_y_i,
  input  logic signed [ttf_pkg::NRM_W-1:0]  norm_z_i,
  output logic [ttf_pkg::IDX_W-1:0]         out_index_o,
  output logic signed [ttf_pkg::UNIT_W-1:0] tan_x_o,
  output logic signed [ttf_pkg::UNIT_W-1:0] tan_y_o,
  output logic signed [ttf_pkg::UNIT_W-1:0] tan_z_o,
  output logic signed [ttf_pkg::UNIT_W-1:0] bin_x_o,
  output logic signed [ttf_pkg::UNIT_W-1:0] bin_y_o,
  output logic signed [ttf_pkg::UNIT_W-1:0] bin_z_o,
  output logic                              last_of_triangle_o
);
  import ttf_pkg::*;

  logic signed [POS_W-1:0]  pos_q [3][3];
  logic signed [NRM_W-1:0]  nrm_q [3][3];
  logic [IDX_KEEP-1:0]      idx_q [3];
  logic signed [UNIT_W-1:0] t_q [3];
  logic signed [31:0]       acc_q;
  logic signed [32:0]       c_q [3];

  logic [IDX_W-1:0]         oidx_q;
  logic signed [UNIT_W-1:0] otan_q [3];
  logic signed [UNIT_W-1:0] obin_q [3];
  logic                     olast_q;

  logic signed [POS_W:0]    diff [3];
  logic signed [NRM_W-1:0]  nsel [3];
  logic [IDX_KEEP-1:0]      isel;
  logic signed [15:0]       mul_a, mul_b;
  logic signed [31:0]       prod;
  logic signed [VEC_W-1:0]  nvec [3];
  logic                     nstart;
  logic                     ndone;
  logic signed [UNIT_W-1:0] nres [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (cmd_i.corner)
        CORNER_0: begin
          diff[k] = 33'(pos_q[1][k]) - 33'(pos_q[0][k]);
          nsel[k] = nrm_q[0][k];
        end
        CORNER_1: begin
          diff[k] = 33'(pos_q[1][k]) - 33'(pos_q[2][k]);
          nsel[k] = nrm_q[1][k];
        end
        default: begin
          diff[k] = 33'(pos_q[0][k]) - 33'(pos_q[2][k]);
          nsel[k] = nrm_q[2][k];
        end
      endcase
      if (cmd_i.odd) diff[k] = -diff[k];
      nvec[k] = cmd_i.tan_go ? VEC_W'(diff[k]) : VEC_W'(c_q[k]);
    end
    case (cmd_i.corner)
      CORNER_0: isel = idx_q[0];
      CORNER_1: isel = idx_q[1];
      default:  isel = idx_q[2];
    endcase
    case (cmd_i.cross_step)
      3'd0:    begin mul_a = nsel[1]; mul_b = t_q[2]; end
      3'd1:    begin mul_a = nsel[2]; mul_b = t_q[1]; end
      3'd2:    begin mul_a = nsel[2]; mul_b = t_q[0]; end
      3'd3:    begin mul_a = nsel[0]; mul_b = t_q[2]; end
      3'd4:    begin mul_a = nsel[0]; mul_b = t_q[1]; end
      default: begin mul_a = nsel[1]; mul_b = t_q[0]; end
    endcase
    prod   = mul_a * mul_b;
    nstart = cmd_i.tan_go | cmd_i.bin_go;
  end

  ttf_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (nstart),
    .vec_i   (nvec),
    .done_o  (ndone),
    .res_o   (nres)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q[cmd_i.slot]    <= vertex_index_i[IDX_KEEP-1:0];
      pos_q[cmd_i.slot][0] <= pos_x_i;
      pos_q[cmd_i.slot][1] <= pos_y_i;
      pos_q[cmd_i.slot][2] <= pos_z_i;
      nrm_q[cmd_i.slot][0] <= norm_x_i;
      nrm_q[cmd_i.slot][1] <= norm_y_i;
      nrm_q[cmd_i.slot][2] <= norm_z_i;
    end
    if (cmd_i.tan_save) t_q <= nres;
    if (cmd_i.cross_en) begin
      if (!cmd_i.cross_step[0]) begin
        acc_q <= prod;
      end else begin
        c_q[cmd_i.cross_step[2:1]] <= 33'(acc_q) - 33'(prod);
      end
    end
    if (cmd_i.put) begin
      oidx_q  <= IDX_W'(isel);
      otan_q  <= t_q;
      obin_q  <= nres;
      olast_q <= (cmd_i.corner == CORNER_2);
    end
  end

  assign sts_o.norm_done  = ndone;
  assign out_index_o      = oidx_q;
  assign tan_x_o          = otan_q[0];
  assign tan_y_o          = otan_q[1];
  assign tan_z_o          = otan_q[2];
  assign bin_x_o          = obin_q[0];
  assign bin_y_o          = obin_q[1];
  assign bin_z_o          = obin_q[2];
  assign last_of_triangle_o = olast_q;

endmodule

### rtl/core/ttf_ctrl.sv
// Controller: corner count, triangle parity and the per-corner sequence
// of tangent, cross product, binormal and output. Uses ttf_pkg.
`include "triangle_tangent_frame_core_assert.svh"
module ttf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              first_i,
  input  logic              out_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output ttf_pkg::ttf_cmd_t cmd_o,
  input  ttf_pkg::ttf_sts_t sts_i
);
  import ttf_pkg::*;

  typedef enum logic [2:0] {
    S_IN, S_TAN_GO, S_TAN_WAIT, S_CROSS, S_BIN_GO, S_BIN_WAIT, S_PUT
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] count_q, count_d;
  logic       odd_q, odd_d;
  logic [1:0] corner_q, corner_d;
  logic [2:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic [1:0] eff;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    odd_d       = odd_q;
    corner_d    = corner_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    cmd_o            = '0;
    cmd_o.corner     = corner_q;
    cmd_o.odd        = odd_q;
    cmd_o.cross_step = step_q;
    eff = first_i ? SLOT_V0 : count_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      S_IN: begin
        cmd_o.slot = eff;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (first_i) odd_d = 1'b0;
          if (eff == SLOT_V2) begin
            count_d  = SLOT_V0;
            corner_d = CORNER_0;
            state_d  = S_TAN_GO;
          end else begin
            count_d = eff + 2'd1;
          end
        end
      end
      S_TAN_GO: begin
        cmd_o.tan_go = 1'b1;
        state_d      = S_TAN_WAIT;
      end
      S_TAN_WAIT: begin
        if (sts_i.norm_done) begin
          cmd_o.tan_save = 1'b1;
          step_d         = '0;
          state_d        = S_CROSS;
        end
      end
      S_CROSS: begin
        cmd_o.cross_en = 1'b1;
        if (step_q == CROSS_LAST) begin
          state_d = S_BIN_GO;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      S_BIN_GO: begin
        cmd_o.bin_go = 1'b1;
        state_d      = S_BIN_WAIT;
      end
      S_BIN_WAIT: begin
        if (sts_i.norm_done) state_d = S_PUT;
      end
      S_PUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.put   = 1'b1;
          out_valid_d = 1'b1;
          if (corner_q == CORNER_2) begin
            odd_d   = !odd_q;
            state_d = S_IN;
          end else begin
            corner_d = corner_q + 2'd1;
            state_d  = S_TAN_GO;
          end
        end
      end
      default: state_d = S_IN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IN;
      count_q     <= SLOT_V0;
      odd_q       <= 1'b0;
      corner_q    <= CORNER_0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      odd_q       <= odd_d;
      corner_q    <= corner_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IN);
  assign out_valid_o = out_valid_q;

  `TTF_ASSERT_NEVER(a_count_range, count_q == 2'd3, "corner count out of range")
  `TTF_ASSERT_NEVER(a_done_unexpected, sts_i.norm_done && !(state_q == S_TAN_WAIT || state_q == S_BIN_WAIT), "normalizer finished outside a wait state")
  `TTF_ASSERT(a_third_starts, (state_q == S_IN && in_valid_i && !first_i && count_q == SLOT_V2) |=> (state_q == S_TAN_GO), "third corner did not start a triangle")
  `TTF_ASSERT(a_put_free, cmd_o.put |-> (!out_valid_q || out_ready_i), "result overwrote a pending item")

endmodule

### tb/triangle_tangent_frame_core_test.sv
// Self-checking testbench for triangle_tangent_frame_core: a queue-fed driver, a
// monitor and a built-in tangent frame predictor. Depends on ttf_pkg and the core RTL.
`timescale 1ns / 1ps
module triangle_tangent_frame_core_test;
  import ttf_pkg::*;

  typedef longint vec3_t [3];

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic signed [POS_W-1:0] pos [3];
    logic signed [NRM_W-1:0] nrm [3];
    logic first;
  } vertex_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic signed [UNIT_W-1:0] tang [3];
    logic signed [UNIT_W-1:0] bin [3];
    logic last;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [IDX_W-1:0] vertex_index_i = '0;
  logic signed [POS_W-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [NRM_W-1:0] norm_x_i = '0, norm_y_i = '0, norm_z_i = '0;
  logic first_of_mesh_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [IDX_W-1:0] out_index_o;
  logic signed [UNIT_W-1:0] tan_x_o, tan_y_o, tan_z_o, bin_x_o, bin_y_o, bin_z_o;
  logic last_of_triangle_o;

  triangle_tangent_frame_core uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  vertex_t pending_vertices [$];
  vertex_t cur_vertex;
  frame_t expected_frames [$];
  int error_count = 0;
  int vertices_sent = 0;
  int frames_checked = 0;
  int total_vertices = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  logic [IDX_W-1:0] held_idx [2];
  longint held_pos [2][3];
  longint held_nrm [2][3];
  int corner_cnt = 0;
  bit odd_tri = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic vec3_t normalize(vec3_t v);
    longint unsigned m [3];
    longint unsigned mx, s, len, q;
    vec3_t o;
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] = v[k] < 0 ? -v[k] : v[k];
      if (m[k] > mx) mx = m[k];
    end
    if (mx == 0) begin
      o = '{0, 0, 0};
      return o;
    end
    while (mx >= (64'd1 << 20)) begin
      mx >>= 1;
      for (int k = 0; k < 3; k++) m[k] >>= 1;
    end
    while (mx < (64'd1 << 19)) begin
      mx <<= 1;
      for (int k = 0; k < 3; k++) m[k] <<= 1;
    end
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(s);
    for (int k = 0; k < 3; k++) begin
      q = (m[k] * 32768 + len) / (2 * len);
      o[k] = v[k] < 0 ? -longint'(q) : longint'(q);
    end
    return o;
  endfunction

  function automatic frame_t corner_frame(vec3_t a, vec3_t b, vec3_t n,
                                          logic [IDX_W-1:0] idx, logic last);
    vec3_t d, t, c, bn;
    frame_t f;
    for (int k = 0; k < 3; k++) d[k] = a[k] - b[k];
    t = normalize(d);
    c[0] = n[1] * t[2] - n[2] * t[1];
    c[1] = n[2] * t[0] - n[0] * t[2];
    c[2] = n[0] * t[1] - n[1] * t[0];
    bn = normalize(c);
    f.idx = idx;
    for (int k = 0; k < 3; k++) begin
      f.tang[k] = t[k][15:0];
      f.bin[k] = bn[k][15:0];
    end
    f.last = last;
    return f;
  endfunction

  task automatic predict_vertex(vertex_t vx);
    vec3_t p [3];
    vec3_t n [3];
    if (vx.first) begin
      corner_cnt = 0;
      odd_tri = 1'b0;
    end
    if (corner_cnt < 2) begin
      held_idx[corner_cnt] = vx.idx;
      for (int k = 0; k < 3; k++) begin
        held_pos[corner_cnt][k] = vx.pos[k];
        held_nrm[corner_cnt][k] = vx.nrm[k];
      end
      corner_cnt++;
    end else begin
      for (int j = 0; j < 2; j++)
        for (int k = 0; k < 3; k++) begin
          p[j][k] = held_pos[j][k];
          n[j][k] = held_nrm[j][k];
        end
      for (int k = 0; k < 3; k++) begin
        p[2][k] = vx.pos[k];
        n[2][k] = vx.nrm[k];
      end
      if (!odd_tri) begin
        expected_frames = {expected_frames, corner_frame(p[1], p[0], n[0], held_idx[0], 1'b0)};
        expected_frames = {expected_frames, corner_frame(p[1], p[2], n[1], held_idx[1], 1'b0)};
        expected_frames = {expected_frames, corner_frame(p[0], p[2], n[2], vx.idx, 1'b1)};
      end else begin
        expected_frames = {expected_frames, corner_frame(p[0], p[1], n[0], held_idx[0], 1'b0)};
        expected_frames = {expected_frames, corner_frame(p[2], p[1], n[1], held_idx[1], 1'b0)};
        expected_frames = {expected_frames, corner_frame(p[2], p[0], n[2], vx.idx, 1'b1)};
      end
      corner_cnt = 0;
      odd_tri = ~odd_tri;
    end
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $time);
    error_count++;
  endtask

  task automatic add_vertex(logic [IDX_W-1:0] idx, logic signed [POS_W-1:0] x,
                            logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z,
                            logic signed [NRM_W-1:0] nx, logic signed [NRM_W-1:0] ny,
                            logic signed [NRM_W-1:0] nz, logic first);
    vertex_t v;
    v.idx = idx;
    v.pos = '{x, y, z};
    v.nrm = '{nx, ny, nz};
    v.first = first;
    pending_vertices = {pending_vertices, v};
  endtask

  function automatic logic signed [POS_W-1:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(2000)) - 1000;
      2: return $signed($urandom_range(200000)) - 100000;
      default: return $signed($urandom) >>> $urandom_range(20);
    endcase
  endfunction

  function automatic logic signed [NRM_W-1:0] rand_nrm();
    if ($urandom_range(3) == 0) return NRM_W'($urandom);
    return NRM_W'($signed($urandom_range(32768)) - 16384);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_vertex(cur_vertex);
        vertices_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_vertices.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_vertex = pending_vertices.pop_front();
          vertex_index_i <= cur_vertex.idx;
          pos_x_i <= cur_vertex.pos[0];
          pos_y_i <= cur_vertex.pos[1];
          pos_z_i <= cur_vertex.pos[2];
          norm_x_i <= cur_vertex.nrm[0];
          norm_y_i <= cur_vertex.nrm[1];
          norm_z_i <= cur_vertex.nrm[2];
          first_of_mesh_i <= cur_vertex.first;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    frame_t w;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("unpredicted result, out_index", out_index_o, -1);
        end else begin
          w = expected_frames.pop_front();
          if (out_index_o !== w.idx) report_mismatch("out_index", out_index_o, w.idx);
          if (tan_x_o !== w.tang[0]) report_mismatch("tan_x", tan_x_o, w.tang[0]);
          if (tan_y_o !== w.tang[1]) report_mismatch("tan_y", tan_y_o, w.tang[1]);
          if (tan_z_o !== w.tang[2]) report_mismatch("tan_z", tan_z_o, w.tang[2]);
          if (bin_x_o !== w.bin[0]) report_mismatch("bin_x", bin_x_o, w.bin[0]);
          if (bin_y_o !== w.bin[1]) report_mismatch("bin_y", bin_y_o, w.bin[1]);
          if (bin_z_o !== w.bin[2]) report_mismatch("bin_z", bin_z_o, w.bin[2]);
          if (last_of_triangle_o !== w.last)
            report_mismatch("last_of_triangle", last_of_triangle_o, w.last);
        end
        frames_checked++;
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // The run goes in quarters: no idling, sender idle, receiver stalling, then both.
  always @(posedge clk_i) begin
    case (vertices_sent * 4 / (total_vertices + 1))
      0: begin
        send_idle_pct <= 0;
        stall_pct <= 0;
      end
      1: begin
        send_idle_pct <= 53;
        stall_pct <= 0;
      end
      2: begin
        send_idle_pct <= 0;
        stall_pct <= 53;
      end
      default: begin
        send_idle_pct <= 37;
        stall_pct <= 37;
      end
    endcase
  end

  initial begin
    logic signed [POS_W-1:0] bx, by, bz;
    // Directed: extremes, zero edges, zero cross products and mesh restarts.
    add_vertex(16'h0000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
               16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
    add_vertex(16'hffff, 32'sh80000000, 32'sh80000000, 32'sh80000000,
               16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    add_vertex(16'h1234, 0, 32'sh7fffffff, 32'sh80000000, 16'sh4000, 0, 0, 1'b0);
    add_vertex(1, 0, 0, 0, 0, 0, 16'sh4000, 1'b0);
    add_vertex(2, 0, 0, 0, 0, 0, 16'sh4000, 1'b0);
    add_vertex(3, 0, 0, 0, 0, 0, 16'sh4000, 1'b0);
    add_vertex(4, 32'sh10000, 0, 0, 16'sh4000, 0, 0, 1'b0);
    add_vertex(5, 32'sh20000, 0, 0, 0, 0, 0, 1'b0);
    add_vertex(6, 32'sh30000, 0, 0, 16'shc000, 0, 0, 1'b0);
    add_vertex(7, 1, 1, 1, 0, 16'sh4000, 0, 1'b0);
    add_vertex(8, 32'sh10000, 0, 0, 0, 16'sh4000, 0, 1'b1);
    add_vertex(9, 0, 32'sh10000, 0, 0, 0, 16'sh4000, 1'b0);
    add_vertex(10, 0, 0, 32'sh10000, 16'sh4000, 0, 0, 1'b0);
    add_vertex(11, -1, 2, -3, 16'sh2d41, 16'shd2bf, 0, 1'b0);
    add_vertex(12, 5, -7, 9, 0, 16'sh2d41, 16'sh2d41, 1'b0);
    add_vertex(13, 32'sh7fffffff, 0, -1, 16'sh7fff, 16'sh8000, 1, 1'b0);
    add_vertex(14, 0, 0, 1, 16'sh1000, 16'sh1000, 16'sh1000, 1'b1);
    add_vertex(15, 32'sh7fff0000, 32'sh8000ffff, 3, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    add_vertex(16, 32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f, 16'sh5555, 16'shaaaa,
               16'sh0f0f, 1'b0);
    while (pending_vertices.size() < 250) begin
      if ($urandom_range(9) == 0) begin
        add_vertex(IDX_W'($urandom), rand_pos(), rand_pos(), rand_pos(),
                   rand_nrm(), rand_nrm(), rand_nrm(), 1'($urandom_range(1)));
      end else begin
        bx = rand_pos();
        by = rand_pos();
        bz = rand_pos();
        for (int j = 0; j < 3; j++) begin
          if ($urandom_range(7) == 0)
            add_vertex(IDX_W'($urandom), bx, by, bz, rand_nrm(), rand_nrm(), rand_nrm(),
                       j == 0 && $urandom_range(4) == 0);
          else
            add_vertex(IDX_W'($urandom), bx + ($signed($urandom) >>> $urandom_range(31)),
                       by + ($signed($urandom) >>> $urandom_range(31)),
                       bz + ($signed($urandom) >>> $urandom_range(31)),
                       rand_nrm(), rand_nrm(), rand_nrm(),
                       j == 0 && $urandom_range(4) == 0);
        end
      end
    end
    total_vertices = pending_vertices.size();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_vertices.size() == 0 && !in_valid_i);
    wait (expected_frames.size() == 0);
    repeat (600) @(posedge clk_i);
    if (expected_frames.size() != 0) begin
      report_mismatch("results outstanding", expected_frames.size(), 0);
    end
    $display("Covered %0d vertices over four idle and stall phases; %0d frames checked.",
             vertices_sent, frames_checked);
    if (error_count == 0) begin
      $display("triangle_tangent_frame_core_test: done, clean");
    end else begin
      $display("triangle_tangent_frame_core_test: done, errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results still expected.", expected_frames.size());
    $display("triangle_tangent_frame_core_test: done, errors");
    $finish;
  end

endmodule
